// ----- hdl/lrup_pkg.sv -----
package lrup_pkg;

  // Number of physical slots in the recency stack.
  localparam int MAX_SLOTS = 32;

  // Fixed field widths.
  localparam int PAGE_W  = 8;
  localparam int CAP_W   = 6;
  localparam int COUNT_W = 16;

  // Occupancy counts from 0 to MAX_SLOTS inclusive.
  localparam int OCC_W = $clog2(MAX_SLOTS + 1);

  // Width in which capacity and occupancy are compared.
  localparam int EFF_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(30);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Commands broadcast from the control logic to every cell.
  typedef struct packed {
    logic step;    // a reference is being applied this cycle
    logic trim;    // drop the least recent page (capacity was lowered)
    logic evict;   // miss with the stack at its capacity
    logic at_top;  // new page goes to the most recent used slot
  } cmd_t;

  // Where a cell sits relative to the current occupancy.
  typedef struct packed {
    logic valid;   // slot holds a resident page
    logic top;     // slot holds the most recent page
    logic ins;     // first free slot
  } pos_t;

endpackage

// ----- hdl/lrup_cell.sv -----
module lrup_cell (
  input  logic                          clk,
  input  logic [lrup_pkg::PAGE_W-1:0]   page,
  input  logic [lrup_pkg::PAGE_W-1:0]   upper,
  input  logic                          seen_in,
  input  lrup_pkg::cmd_t                cmd,
  input  lrup_pkg::pos_t                pos,
  output logic [lrup_pkg::PAGE_W-1:0]   data,
  output logic                          seen_out
);

  logic match;
  logic shift;
  logic load;

  // The seen flag ripples up the row: it is set from the matching slot onward.
  assign match    = pos.valid && (data == page);
  assign seen_out = seen_in || match;

  assign shift = pos.valid && (cmd.trim || cmd.evict || (cmd.step && seen_out));
  assign load  = cmd.step && (cmd.at_top ? pos.top : pos.ins);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= page;
    end else if (shift) begin
      data <= upper;
    end
  end

endmodule

// ----- hdl/lrup_stack.sv -----
module lrup_stack (
  input  logic                          clk,
  input  logic [lrup_pkg::PAGE_W-1:0]   page,
  input  logic [lrup_pkg::OCC_W-1:0]    occupancy,
  input  lrup_pkg::cmd_t                cmd,
  output logic                          hit,
  output logic [lrup_pkg::PAGE_W-1:0]   oldest
);

  logic [lrup_pkg::PAGE_W-1:0] data [lrup_pkg::MAX_SLOTS];
  logic [lrup_pkg::PAGE_W-1:0] upper [lrup_pkg::MAX_SLOTS];
  logic [lrup_pkg::MAX_SLOTS:0] seen;
  lrup_pkg::pos_t               pos [lrup_pkg::MAX_SLOTS];

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < lrup_pkg::MAX_SLOTS; i++) begin : g_slot
    assign pos[i].valid = occupancy > lrup_pkg::OCC_W'(i);
    assign pos[i].top   = occupancy == lrup_pkg::OCC_W'(i + 1);
    assign pos[i].ins   = occupancy == lrup_pkg::OCC_W'(i);

    if (i == lrup_pkg::MAX_SLOTS - 1) begin : g_last
      assign upper[i] = '0;
    end else begin : g_mid
      assign upper[i] = data[i+1];
    end

    lrup_cell u_cell (
      .clk      (clk),
      .page     (page),
      .upper    (upper[i]),
      .seen_in  (seen[i]),
      .cmd      (cmd),
      .pos      (pos[i]),
      .data     (data[i]),
      .seen_out (seen[i+1])
    );
  end

  assign hit    = seen[lrup_pkg::MAX_SLOTS];
  assign oldest = data[0];

endmodule

// ----- hdl/lru_page_replacement.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | page_id
// out      | out_valid / out_ready| hit, evicted, evicted_page, replacement_count
// cfg      | cfg_valid / cfg_ready| capacity
//
// A reference is taken when in_valid and in_ready are both high, and its result sits in the
// output register in the cycle after; a new reference is taken in the cycle that result is unloaded.
// A stalled result holds in_ready low until out_ready returns.
// Lowering the capacity below the occupancy trims one page per cycle afterward, and
// input and configuration transfers are held off until the trim is done.
// Reset (rst, synchronous) empties the stack, clears the count and sets capacity to 30.
module lru_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrup_pkg::PAGE_W-1:0]     page_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic                            evicted,
  output logic [lrup_pkg::PAGE_W-1:0]     evicted_page,
  output logic [lrup_pkg::COUNT_W-1:0]    replacement_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrup_pkg::CAP_W-1:0]      capacity
);

  // Capacity register and occupancy of the stack.
  logic [lrup_pkg::CAP_W-1:0]   cap;
  logic [lrup_pkg::OCC_W-1:0]   occupancy;
  logic [lrup_pkg::OCC_W-1:0]   occupancy_next;
  logic [lrup_pkg::COUNT_W-1:0] replacements;
  logic [lrup_pkg::COUNT_W-1:0] replacements_next;

  logic [lrup_pkg::EFF_W-1:0] eff;
  logic [lrup_pkg::EFF_W-1:0] occ_ext;
  logic                       full;
  logic                       trimming;
  logic                       step;
  logic                       stack_hit;
  logic [lrup_pkg::PAGE_W-1:0] oldest;
  lrup_pkg::cmd_t             cmd;

  // A zero capacity behaves as one slot; anything above the slot count saturates.
  always_comb begin
    if (cap == '0) begin
      eff = lrup_pkg::EFF_W'(1);
    end else if (lrup_pkg::EFF_W'(cap) > lrup_pkg::EFF_W'(lrup_pkg::MAX_SLOTS)) begin
      eff = lrup_pkg::EFF_W'(lrup_pkg::MAX_SLOTS);
    end else begin
      eff = lrup_pkg::EFF_W'(cap);
    end
  end

  assign occ_ext  = lrup_pkg::EFF_W'(occupancy);
  assign full     = occ_ext >= eff;
  assign trimming = occ_ext > eff;

  assign in_ready  = !trimming && (!out_valid || out_ready);
  assign cfg_ready = !trimming;
  assign step      = in_valid && in_ready;

  // The evict command depends on the hit flag, which the cells produce from the
  // compare chain alone, so there is no loop through the row.
  assign cmd.step   = step;
  assign cmd.trim   = trimming;
  assign cmd.evict  = step && !stack_hit && full;
  assign cmd.at_top = stack_hit || full;

  lrup_stack u_stack (
    .clk       (clk),
    .page      (page_id),
    .occupancy (occupancy),
    .cmd       (cmd),
    .hit       (stack_hit),
    .oldest    (oldest)
  );

  always_comb begin
    occupancy_next    = occupancy;
    replacements_next = replacements;
    if (trimming) begin
      occupancy_next = occupancy - lrup_pkg::OCC_W'(1);
    end else if (step && !stack_hit) begin
      if (full) begin
        if (replacements != lrup_pkg::COUNT_MAX) begin
          replacements_next = replacements + lrup_pkg::COUNT_W'(1);
        end
      end else begin
        occupancy_next = occupancy + lrup_pkg::OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= lrup_pkg::CAP_RESET;
      occupancy    <= '0;
      replacements <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= capacity;
      end
      occupancy    <= occupancy_next;
      replacements <= replacements_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; loaded only when a reference transfer takes place.
  always_ff @(posedge clk) begin
    if (step) begin
      hit               <= stack_hit;
      evicted           <= cmd.evict;
      evicted_page      <= cmd.evict ? oldest : '0;
      replacement_count <= replacements_next;
    end
  end

  // Occupancy never runs past the physical slot count.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    lrup_pkg::EFF_W'(occupancy) <= lrup_pkg::EFF_W'(lrup_pkg::MAX_SLOTS))
    else $error("occupancy exceeds slot count");

  // A hit leaves the occupancy unchanged.
  a_hit_occ: assert property (@(posedge clk) disable iff (rst)
    step && stack_hit |=> $stable(occupancy))
    else $error("occupancy changed on a hit");

  // A result never reports both a hit and an eviction.
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and eviction reported together");

  // The replacement count only moves on an eviction.
  a_count: assert property (@(posedge clk) disable iff (rst)
    !cmd.evict |=> $stable(replacements))
    else $error("replacement count changed without eviction");

endmodule
